// ===== hdl/rtr_pkg.sv =====
// ============================================================================
// rtr_pkg: shared types and constants of the record-then-replay sample memory
// Holds field widths, register indexes, reset values and the hysteresis
// edge detector used on the clear, rewind and trigger inputs.
// ============================================================================
package rtr_pkg;

    localparam int SMP_W       = 16;
    localparam int CNT_W       = 15;
    localparam int POS_W       = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INPUT_CONNECTED = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GATE_CONNECTED  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_HIGH       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_LOW        = 3'd4;

    // Reset values and fixed levels (2048 codes per volt).
    localparam logic [CNT_W-1:0]        CAPACITY_RESET  = 15'd128;
    localparam logic signed [SMP_W-1:0] EDGE_HIGH_RESET = 16'sd2048;
    localparam logic signed [SMP_W-1:0] EDGE_LOW_RESET  = 16'sd0;
    localparam logic signed [SMP_W-1:0] GATE_ON_LEVEL   = 16'sd2048;

    // Detector bit positions inside the armed vector.
    localparam int DET_CLEAR  = 0;
    localparam int DET_REWIND = 1;
    localparam int DET_TRIG   = 2;

    // Where the held output value comes from for one word.
    typedef enum logic [1:0] {
        SRC_HOLD,
        SRC_READ,
        SRC_VALUE
    } src_t;

    // One word on its way from the control stage to the output stage.
    typedef struct packed {
        src_t                    src;
        logic signed [SMP_W-1:0] value;
        logic                    read_lamp;
        logic                    write_lamp;
        logic                    noise_lamp;
        logic [CNT_W-1:0]        fill_count;
    } stage_t;

    // Hysteresis edge detector. Returns {fire, armed_next}. An armed detector
    // waits for the level to fall to the low threshold before it may fire again.
    function automatic logic [1:0] detect(
        input logic                    armed,
        input logic signed [SMP_W-1:0] level,
        input logic signed [SMP_W-1:0] high_level,
        input logic signed [SMP_W-1:0] low_level
    );
        logic fire;
        logic armed_next;
        fire       = 1'b0;
        armed_next = armed;
        if (armed) begin
            if (level <= low_level) begin
                armed_next = 1'b0;
            end
        end else if (level >= high_level) begin
            armed_next = 1'b1;
            fire       = 1'b1;
        end
        return {fire, armed_next};
    endfunction

endpackage

// ===== hdl/rtr_store.sv =====
// ============================================================================
// rtr_store: sample memory
// Single write port and one read port with a registered read.
// The read data holds until the next read.
// ============================================================================
module rtr_store
    import rtr_pkg::*;
#(
    parameter int STORE_DEPTH = 16384,
    parameter int AW          = 14
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    wr_en,
    input  logic [AW-1:0]           wr_addr,
    input  logic signed [SMP_W-1:0] wr_data,
    input  logic                    rd_en,
    input  logic [AW-1:0]           rd_addr,
    output logic signed [SMP_W-1:0] rd_data
);

    logic signed [SMP_W-1:0] mem [STORE_DEPTH];
    logic signed [SMP_W-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

`ifndef SYNTH
    // One word either replays or appends, never both.
    a_no_rd_wr_same_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        !(rd_en && wr_en))
        else $error("store read and write issued for the same word");
`endif

endmodule

// ===== hdl/rtr_ctrl.sv =====
// ============================================================================
// rtr_ctrl: control stage
// Holds the configuration, the fill count, the play position, the mode
// flags, the idle timer and the edge detectors. For each accepted word it
// updates that state and issues at most one memory read or write.
// ============================================================================
module rtr_ctrl
    import rtr_pkg::*;
#(
    parameter int STORE_DEPTH = 16384,
    parameter int IDLE_TICKS  = 1152000,
    parameter int AW          = 14
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // Configuration
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_wdata,
    // Accepted input word
    input  logic                    accept,
    input  logic signed [SMP_W-1:0] trig_level,
    input  logic signed [SMP_W-1:0] clear_level,
    input  logic signed [SMP_W-1:0] rewind_level,
    input  logic signed [SMP_W-1:0] gate_level,
    input  logic signed [SMP_W-1:0] in_sample,
    input  logic signed [SMP_W-1:0] noise_sample,
    // Memory commands
    output logic                    wr_en,
    output logic [AW-1:0]           wr_addr,
    output logic signed [SMP_W-1:0] wr_data,
    output logic                    rd_en,
    output logic [AW-1:0]           rd_addr,
    // Word for the output stage
    output stage_t                  stage
);

    localparam int IW = $clog2(IDLE_TICKS + 1);
    localparam logic [IW-1:0] IDLE_LOAD = IW'(IDLE_TICKS);
    localparam logic [16:0] DEPTH_EXT = 17'(STORE_DEPTH);
    localparam logic [CNT_W-1:0] CAP_INIT =
        (STORE_DEPTH < 128) ? CNT_W'(STORE_DEPTH) : CAPACITY_RESET;

    // Configuration registers
    logic [CNT_W-1:0]        cap_reg, cap_next;
    logic                    in_conn_reg, in_conn_next;
    logic                    gate_conn_reg, gate_conn_next;
    logic signed [SMP_W-1:0] hi_reg, hi_next;
    logic signed [SMP_W-1:0] lo_reg, lo_next;

    // Block state
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic signed [POS_W-1:0] pos_reg, pos_next;
    logic                    rd_flag_reg, rd_flag_next;
    logic                    wr_flag_reg, wr_flag_next;
    logic                    nz_flag_reg, nz_flag_next;
    logic                    idle_reg, idle_next;
    logic [IW-1:0]           cd_reg, cd_next;
    logic [2:0]              armed_reg, armed_next;

    // Item datapath
    logic [1:0]              det_clr, det_rew, det_trig;
    logic                    write_gate;
    logic [CNT_W-1:0]        cnt0;
    logic signed [POS_W-1:0] pos0;
    logic signed [16:0]      pos_inc, pos_sat;
    logic [16:0]             cnt_ext;
    logic                    do_read, do_write;
    logic signed [SMP_W-1:0] value;
    src_t                    src;
    logic [16:0]             cap_wr_ext;
    logic [CNT_W-1:0]        cap_wr;

    assign det_clr    = detect(armed_reg[DET_CLEAR], clear_level, hi_reg, lo_reg);
    assign det_rew    = detect(armed_reg[DET_REWIND], rewind_level, hi_reg, lo_reg);
    assign det_trig   = detect(armed_reg[DET_TRIG], trig_level, hi_reg, lo_reg);
    assign write_gate = gate_conn_reg && (gate_level >= GATE_ON_LEVEL);

    // Clear and rewind act before the trigger.
    assign cnt0    = det_clr[1] ? '0 : cnt_reg;
    assign pos0    = (det_clr[1] || det_rew[1]) ? -16'sd1 : pos_reg;
    assign pos_inc = {pos0[POS_W-1], pos0} + 17'sd1;
    assign pos_sat = (pos_inc > $signed({2'b00, cap_reg})) ? $signed({2'b00, cap_reg})
                                                           : pos_inc;
    assign cnt_ext = {2'b00, cnt0};

    // Per-word state update.
    always_comb begin
        armed_next   = {det_trig[0], det_rew[0], det_clr[0]};
        cnt_next     = cnt0;
        pos_next     = pos0;
        rd_flag_next = rd_flag_reg && !(det_clr[1] || det_rew[1]);
        wr_flag_next = wr_flag_reg && !(det_clr[1] || det_rew[1]);
        nz_flag_next = nz_flag_reg && !(det_clr[1] || det_rew[1]);
        idle_next    = (cd_reg == '0) ? 1'b1 : idle_reg;
        cd_next      = ((cd_reg == '0) ? IDLE_LOAD : cd_reg) - IW'(1);
        do_read      = 1'b0;
        do_write     = 1'b0;
        value        = noise_sample;
        src          = SRC_HOLD;
        if (det_trig[1]) begin
            idle_next = 1'b0;
            cd_next   = IDLE_LOAD;
            pos_next  = pos_sat[POS_W-1:0];
            if (($signed({2'b00, cnt0}) > pos_sat) && !write_gate) begin
                rd_flag_next = 1'b1;
                wr_flag_next = 1'b0;
                nz_flag_next = 1'b0;
                do_read      = 1'b1;
                src          = SRC_READ;
            end else begin
                rd_flag_next = 1'b0;
                src          = SRC_VALUE;
                if ($signed({2'b00, cap_reg}) > pos_sat) begin
                    wr_flag_next = 1'b1;
                    if (in_conn_reg) begin
                        value = in_sample;
                    end else begin
                        nz_flag_next = 1'b1;
                    end
                    // A forced write into a full store is shown but not kept.
                    if (cnt0 < cap_reg) begin
                        do_write = 1'b1;
                        cnt_next = cnt0 + CNT_W'(1);
                    end
                end else begin
                    wr_flag_next = 1'b0;
                    nz_flag_next = 1'b1;
                end
            end
        end
    end

    // Capacity writes saturate at the store depth.
    assign cap_wr_ext = {2'b00, cfg_wdata[CNT_W-1:0]};
    assign cap_wr     = (cap_wr_ext > DEPTH_EXT) ? CNT_W'(STORE_DEPTH) : cap_wr_ext[CNT_W-1:0];

    // Configuration decode.
    always_comb begin
        cap_next       = cap_reg;
        in_conn_next   = in_conn_reg;
        gate_conn_next = gate_conn_reg;
        hi_next        = hi_reg;
        lo_next        = lo_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                REG_CAPACITY:        cap_next       = cap_wr;
                REG_INPUT_CONNECTED: in_conn_next   = cfg_wdata[0];
                REG_GATE_CONNECTED:  gate_conn_next = cfg_wdata[0];
                REG_EDGE_HIGH:       hi_next        = $signed(cfg_wdata);
                REG_EDGE_LOW:        lo_next        = $signed(cfg_wdata);
                default: begin
                end
            endcase
        end
    end

    // State registers. A capacity write truncates the fill count unless a word is accepted.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg       <= CAP_INIT;
            in_conn_reg   <= 1'b0;
            gate_conn_reg <= 1'b0;
            hi_reg        <= EDGE_HIGH_RESET;
            lo_reg        <= EDGE_LOW_RESET;
            cnt_reg       <= '0;
            pos_reg       <= -16'sd1;
            rd_flag_reg   <= 1'b0;
            wr_flag_reg   <= 1'b0;
            nz_flag_reg   <= 1'b0;
            idle_reg      <= 1'b1;
            cd_reg        <= '0;
            armed_reg     <= 3'b111;
        end else begin
            cap_reg       <= cap_next;
            in_conn_reg   <= in_conn_next;
            gate_conn_reg <= gate_conn_next;
            hi_reg        <= hi_next;
            lo_reg        <= lo_next;
            if (accept) begin
                cnt_reg     <= cnt_next;
                pos_reg     <= pos_next;
                rd_flag_reg <= rd_flag_next;
                wr_flag_reg <= wr_flag_next;
                nz_flag_reg <= nz_flag_next;
                idle_reg    <= idle_next;
                cd_reg      <= cd_next;
                armed_reg   <= armed_next;
            end else if (cfg_we && (cfg_index == REG_CAPACITY) && (cnt_reg > cap_wr)) begin
                cnt_reg <= cap_wr;
            end
        end
    end

    // Memory commands.
    assign wr_en   = accept && do_write;
    assign wr_addr = cnt_ext[AW-1:0];
    assign wr_data = value;
    assign rd_en   = accept && do_read;
    assign rd_addr = pos_sat[AW-1:0];

    // Word for the output stage, carrying the state after this word.
    always_comb begin
        stage.src        = src;
        stage.value      = value;
        stage.read_lamp  = rd_flag_next;
        stage.write_lamp = wr_flag_next;
        stage.noise_lamp = nz_flag_next && !idle_next;
        stage.fill_count = cnt_next;
    end

`ifndef SYNTH
    // An append only ever lands below the capacity.
    a_write_below_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (cnt0 < cap_reg))
        else $error("append issued with a full store");

    // After a trigger the position never passes the capacity.
    a_pos_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && det_trig[1]) |=> (pos_reg <= $signed({1'b0, cap_reg})))
        else $error("play position beyond capacity after a trigger");
`endif

endmodule

// ===== hdl/rtr_out.sv =====
// ============================================================================
// rtr_out: output stage
// Holds each word in stage B while the memory read data arrives, resolves the
// held value and loads the result register. Produces the input ready.
// ============================================================================
module rtr_out
    import rtr_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  stage_t                  stage,
    input  logic signed [SMP_W-1:0] rd_data,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [SMP_W-1:0] m_out_sample,
    output logic                    m_read_lamp,
    output logic                    m_write_lamp,
    output logic                    m_noise_lamp,
    output logic [CNT_W-1:0]        m_fill_count
);

    logic                    b_valid_reg;
    stage_t                  b_reg;
    logic signed [SMP_W-1:0] held_reg, held_next;
    logic                    m_valid_reg;
    logic signed [SMP_W-1:0] out_sample_reg;
    logic                    read_lamp_reg, write_lamp_reg, noise_lamp_reg;
    logic [CNT_W-1:0]        fill_count_reg;
    logic                    accept, advance;

    // Stage B moves when the result register is empty or being taken.
    assign advance = b_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !b_valid_reg || !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // Held value selection.
    always_comb begin
        case (b_reg.src)
            SRC_READ:  held_next = rd_data;
            SRC_VALUE: held_next = b_reg.value;
            default:   held_next = held_reg;
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            held_reg    <= '0;
        end else begin
            if (accept) begin
                b_valid_reg <= 1'b1;
            end else if (advance) begin
                b_valid_reg <= 1'b0;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
                held_reg    <= held_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            b_reg <= stage;
        end
        if (advance) begin
            out_sample_reg <= held_next;
            read_lamp_reg  <= b_reg.read_lamp;
            write_lamp_reg <= b_reg.write_lamp;
            noise_lamp_reg <= b_reg.noise_lamp;
            fill_count_reg <= b_reg.fill_count;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_sample = out_sample_reg;
    assign m_read_lamp  = read_lamp_reg;
    assign m_write_lamp = write_lamp_reg;
    assign m_noise_lamp = noise_lamp_reg;
    assign m_fill_count = fill_count_reg;

`ifndef SYNTH
    // A new word never overwrites a stage B word that is stuck.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |-> (!b_valid_reg || advance))
        else $error("stage B word overwritten");
`endif

endmodule

// ===== hdl/record_then_replay_sample_memory.sv =====
// ============================================================================
// record_then_replay_sample_memory: top level
// Records samples on trigger edges into a sample memory and replays them,
// with clear and rewind detectors, a write gate and an idle timer.
// ============================================================================
//
//  Channel  Direction  Handshake           Payload
//  s_       in         s_valid / s_ready   six signed 16-bit levels and samples
//  m_       out        m_valid / m_ready   sample, three lamps, fill count
//  cfg_     in         cfg_we              cfg_index, cfg_wdata
//
//  One word is accepted per cycle while s_ready is high; each word passes
//  through stage B, where the registered memory read lands, to the result register.
//  The memory holds no reset state; only entries below the fill count are read.
//  Reset is synchronous and active low and clears all control state.
//  A stalled result holds one word in the memory-read stage; input ready
//  falls only when both that stage and the result register are full.
//
module record_then_replay_sample_memory
    import rtr_pkg::*;
#(
    parameter int STORE_DEPTH = 16384,
    parameter int IDLE_TICKS  = 1152000
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [SMP_W-1:0] s_trig_level,
    input  logic signed [SMP_W-1:0] s_clear_level,
    input  logic signed [SMP_W-1:0] s_rewind_level,
    input  logic signed [SMP_W-1:0] s_gate_level,
    input  logic signed [SMP_W-1:0] s_in_sample,
    input  logic signed [SMP_W-1:0] s_noise_sample,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [SMP_W-1:0] m_out_sample,
    output logic                    m_read_lamp,
    output logic                    m_write_lamp,
    output logic                    m_noise_lamp,
    output logic [CNT_W-1:0]        m_fill_count
);

    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    logic                    accept;
    logic                    wr_en, rd_en;
    logic [AW-1:0]           wr_addr, rd_addr;
    logic signed [SMP_W-1:0] wr_data, rd_data;
    stage_t                  stage;

    assign accept = s_valid && s_ready;

    // Control stage: state update and memory command.
    rtr_ctrl #(
        .STORE_DEPTH (STORE_DEPTH),
        .IDLE_TICKS  (IDLE_TICKS),
        .AW          (AW)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .accept       (accept),
        .trig_level   (s_trig_level),
        .clear_level  (s_clear_level),
        .rewind_level (s_rewind_level),
        .gate_level   (s_gate_level),
        .in_sample    (s_in_sample),
        .noise_sample (s_noise_sample),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .stage        (stage)
    );

    // Sample memory.
    rtr_store #(
        .STORE_DEPTH (STORE_DEPTH),
        .AW          (AW)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Output stage and result register.
    rtr_out u_out (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .stage        (stage),
        .rd_data      (rd_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_sample (m_out_sample),
        .m_read_lamp  (m_read_lamp),
        .m_write_lamp (m_write_lamp),
        .m_noise_lamp (m_noise_lamp),
        .m_fill_count (m_fill_count)
    );

endmodule
